/* rtl/assert_macros.svh */
// Assertion shorthands shared by the checker files.
// Both macros sample on clk_i and are switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CHK_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("port check failed");

// Consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("port check failed");

`endif

/* rtl/cuba_lif_pkg.sv */
package cuba_lif_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int DECAY_BITS     = 16;
  localparam int DIGIT_BITS     = 16;

  localparam int SAMPLE_W   = 32;
  localparam int OUT_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int THR_W      = 31;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYN_DECAY = 3'd0,
    CFG_MEM_DECAY = 3'd1,
    CFG_IN_WEIGHT = 3'd2,
    CFG_MEM_RES   = 3'd3,
    CFG_LEAK_POT  = 3'd4,
    CFG_FIRE_THR  = 3'd5,
    CFG_RESET_POT = 3'd6,
    CFG_SUB_MODE  = 3'd7
  } cfg_idx_e;

  localparam logic [DECAY_BITS-1:0] SYN_DECAY_RST = 16'd58982;
  localparam logic [DECAY_BITS-1:0] MEM_DECAY_RST = 16'd58982;
  localparam logic [31:0]           IN_WEIGHT_RST = 32'd65536;
  localparam logic [31:0]           MEM_RES_RST   = 32'd65536;
  localparam logic [31:0]           LEAK_POT_RST  = 32'd0;
  localparam logic [THR_W-1:0]      FIRE_THR_RST  = 31'd65536;
  localparam logic [31:0]           RESET_POT_RST = 32'd0;
  localparam logic                  SUB_MODE_RST  = 1'b0;

  // Request to the shared multiplier.
  typedef struct packed {
    logic start;
    logic neg;
    logic frac_shift;
  } mul_ctl_t;

endpackage

/* rtl/cuba_lif_mul.sv */
module cuba_lif_mul #(
  parameter int DATA_WIDTH = cuba_lif_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cuba_lif_pkg::FRAC_BITS_DEF,
  localparam int MagW      = (DATA_WIDTH > 32) ? DATA_WIDTH : 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cuba_lif_pkg::mul_ctl_t       ctl_i,
  input  logic [MagW-1:0]              a_mag_i,
  input  logic [MagW-1:0]              b_mag_i,
  output logic                         done_o,
  output logic signed [DATA_WIDTH-1:0] term_o
);

  localparam int DigW   = cuba_lif_pkg::DIGIT_BITS;
  localparam int DigLog = $clog2(DigW);
  localparam int PW     = 2 * MagW;
  localparam int PartW  = MagW + DigW;
  localparam int NDig   = (MagW + DigW - 1) / DigW;
  localparam int KW     = $clog2(NDig);
  localparam int ShW    = KW + DigLog;

  localparam logic [PW:0] LimPos = {{(PW + 2 - DATA_WIDTH){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [PW:0] LimNeg = LimPos + 1'b1;
  localparam logic [PW:0] RndDec = (PW+1)'(1) << (cuba_lif_pkg::DECAY_BITS - 1);
  localparam logic [PW:0] RndVal = (PW+1)'(1) << (FRAC_BITS - 1);

  logic                  run_q, rnd_q, done_q;
  logic [KW-1:0]         k_q;
  logic [MagW-1:0]       a_q, b_q, b_next;
  logic [PW-1:0]         acc_q, part_sh;
  logic [PartW-1:0]      part;
  logic [ShW-1:0]        shamt;
  logic                  neg_q, frac_q;
  logic [PW:0]           rsum, shifted, lim, mag;
  logic [DATA_WIDTH-1:0] mag_lo, term_d;
  logic [DATA_WIDTH-1:0] term_q;

  // One 16-bit digit of b per cycle against the full a magnitude.
  always_comb begin
    part    = a_q * b_q[DigW-1:0];
    shamt   = {k_q, {DigLog{1'b0}}};
    part_sh = PW'(part) << shamt;
    b_next  = b_q >> DigW;
  end

  // Round half away from zero on the magnitude, clamp, then apply the sign.
  always_comb begin
    rsum    = {1'b0, acc_q} + (frac_q ? RndVal : RndDec);
    shifted = frac_q ? (rsum >> FRAC_BITS) : (rsum >> cuba_lif_pkg::DECAY_BITS);
    lim     = neg_q ? LimNeg : LimPos;
    mag     = (shifted > lim) ? lim : shifted;
    mag_lo  = mag[DATA_WIDTH-1:0];
    term_d  = neg_q ? (~mag_lo + 1'b1) : mag_lo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      rnd_q  <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        run_q <= 1'b1;
        rnd_q <= 1'b0;
        k_q   <= '0;
      end else if (run_q) begin
        k_q <= k_q + 1'b1;
        if (b_next == '0) begin
          run_q <= 1'b0;
          rnd_q <= 1'b1;
        end
      end else if (rnd_q) begin
        rnd_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      a_q    <= a_mag_i;
      b_q    <= b_mag_i;
      acc_q  <= '0;
      neg_q  <= ctl_i.neg;
      frac_q <= ctl_i.frac_shift;
    end else if (run_q) begin
      acc_q <= acc_q + part_sh;
      b_q   <= b_next;
    end else if (rnd_q) begin
      term_q <= term_d;
    end
  end

  assign done_o = done_q;
  assign term_o = term_q;

endmodule

/* rtl/cuba_lif_neuron_step.sv */
// A new input word is taken only while the sequencer is idle, which it reaches again as
//   the previous result word is loaded; the single digit-serial multiplier carries all
//   six products of a step one after another.
// Reset: current and membrane clear to zero, registers load their default values,
//   no result is pending and the input side is ready.
module cuba_lif_neuron_step #(
  parameter int DATA_WIDTH = cuba_lif_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cuba_lif_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [cuba_lif_pkg::SAMPLE_W-1:0]     s_axis_tdata,  // [31:0] in_sample
  // result stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [2*cuba_lif_pkg::OUT_W-1:0]      m_axis_tdata,  // [31:0] cur_out, [63:32] vm_out
  output logic                                  m_axis_tuser,  // [0] spike
  // register write channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [cuba_lif_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [cuba_lif_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int MagW = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;  // operand magnitude width
  localparam int TW   = MagW + 2;                             // wide signed work width
  localparam int SW   = DATA_WIDTH + 2;                       // sum of up to three terms
  localparam int DW   = cuba_lif_pkg::DECAY_BITS;

  localparam logic signed [TW-1:0] SatMax =
    {{(TW - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [TW-1:0] SatMin = ~SatMax;

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_SAT  = 2'd2;
  localparam logic [1:0] S_FIRE = 2'd3;

  // Product order: both current terms, the two membrane terms that do not need the
  // new current, then the drive term, then resistance times drive.
  localparam logic [2:0] OP_SYN   = 3'd0;  // syn_current * syn_decay
  localparam logic [2:0] OP_IN    = 3'd1;  // in_weight * in_sample
  localparam logic [2:0] OP_MEM   = 3'd2;  // membrane * mem_decay
  localparam logic [2:0] OP_LEAK  = 3'd3;  // leak_potential * (1 - mem_decay)
  localparam logic [2:0] OP_DRIVE = 3'd4;  // new current * (1 - mem_decay)
  localparam logic [2:0] OP_RES   = 3'd5;  // mem_resistance * drive

  function automatic logic signed [DATA_WIDTH-1:0] sat_dw(input logic signed [TW-1:0] x);
    if (x > SatMax) return SatMax[DATA_WIDTH-1:0];
    if (x < SatMin) return SatMin[DATA_WIDTH-1:0];
    return x[DATA_WIDTH-1:0];
  endfunction

  function automatic logic [MagW-1:0] mag_of(input logic signed [MagW-1:0] v);
    return v[MagW-1] ? (~v + 1'b1) : v;
  endfunction

  // Configuration registers.
  logic [DW-1:0]                        syn_decay_q, mem_decay_q;
  logic signed [31:0]                   in_weight_q, mem_res_q, leak_pot_q, reset_pot_q;
  logic [cuba_lif_pkg::THR_W-1:0]       fire_thr_q;
  logic                                 sub_mode_q;
  logic [DW:0]                          omd;

  // Sequencer and neuron state.
  logic [1:0]                           state_q, state_d;
  logic [2:0]                           op_q, op_d;
  logic signed [DATA_WIDTH-1:0]         syn_current_q, membrane_q;
  logic signed [31:0]                   sample_q;
  logic signed [SW-1:0]                 sum_cur_q, sum_mem_q;
  logic signed [DATA_WIDTH-1:0]         cur_q, mem_q;

  // Shared multiplier.
  cuba_lif_pkg::mul_ctl_t               mul_ctl;
  logic                                 mul_start;
  logic signed [MagW-1:0]               opa, opb;
  logic                                 mul_done;
  logic signed [DATA_WIDTH-1:0]         mul_term;

  // Firing and the result register.
  logic                                 s_accept, out_free;
  logic signed [DATA_WIDTH-1:0]         thr_sat, rp_sat, vm_new;
  logic                                 fired;
  logic signed [MagW-1:0]               cur_ext, vm_ext;
  logic                                 out_valid_q, out_spike_q;
  logic [2*cuba_lif_pkg::OUT_W-1:0]     out_data_q;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // 1 - mem_decay as an unsigned Q1.16 value in 1..65536.
  assign omd = (DW+1)'(1 << DW) - (DW+1)'(mem_decay_q);

  // Register writes are taken at any time; software writes only while idle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      syn_decay_q <= cuba_lif_pkg::SYN_DECAY_RST;
      mem_decay_q <= cuba_lif_pkg::MEM_DECAY_RST;
      in_weight_q <= cuba_lif_pkg::IN_WEIGHT_RST;
      mem_res_q   <= cuba_lif_pkg::MEM_RES_RST;
      leak_pot_q  <= cuba_lif_pkg::LEAK_POT_RST;
      fire_thr_q  <= cuba_lif_pkg::FIRE_THR_RST;
      reset_pot_q <= cuba_lif_pkg::RESET_POT_RST;
      sub_mode_q  <= cuba_lif_pkg::SUB_MODE_RST;
    end else if (cfg_valid_i) begin
      unique case (cuba_lif_pkg::cfg_idx_e'(cfg_index_i))
        cuba_lif_pkg::CFG_SYN_DECAY: syn_decay_q <= cfg_data_i[DW-1:0];
        cuba_lif_pkg::CFG_MEM_DECAY: mem_decay_q <= cfg_data_i[DW-1:0];
        cuba_lif_pkg::CFG_IN_WEIGHT: in_weight_q <= cfg_data_i;
        cuba_lif_pkg::CFG_MEM_RES:   mem_res_q   <= cfg_data_i;
        cuba_lif_pkg::CFG_LEAK_POT:  leak_pot_q  <= cfg_data_i;
        cuba_lif_pkg::CFG_FIRE_THR:  fire_thr_q  <= cfg_data_i[cuba_lif_pkg::THR_W-1:0];
        cuba_lif_pkg::CFG_RESET_POT: reset_pot_q <= cfg_data_i;
        cuba_lif_pkg::CFG_SUB_MODE:  sub_mode_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Sequencer: start a product on accept and on each finished product, until the
  // resistance term is in; then saturate the membrane and fire.
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    mul_start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          mul_start = 1'b1;
          op_d      = OP_SYN;
          state_d   = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          if (op_q == OP_RES) begin
            state_d = S_SAT;
          end else begin
            mul_start = 1'b1;
            op_d      = op_q + 3'd1;
          end
        end
      end
      S_SAT: state_d = S_FIRE;
      S_FIRE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Operands of the product being started. Magnitudes go to the multiplier, the
  // sign travels alongside.
  always_comb begin
    case (op_d)
      OP_SYN: begin
        opa = MagW'(syn_current_q);
        opb = MagW'(syn_decay_q);
      end
      OP_IN: begin
        opa = MagW'(in_weight_q);
        opb = MagW'(sample_q);
      end
      OP_MEM: begin
        opa = MagW'(membrane_q);
        opb = MagW'(mem_decay_q);
      end
      OP_LEAK: begin
        opa = MagW'(leak_pot_q);
        opb = MagW'(omd);
      end
      OP_DRIVE: begin
        opa = MagW'(cur_q);
        opb = MagW'(omd);
      end
      OP_RES: begin
        opa = MagW'(mem_res_q);
        opb = MagW'(mul_term);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
    mul_ctl.start      = mul_start;
    mul_ctl.neg        = opa[MagW-1] ^ opb[MagW-1];
    mul_ctl.frac_shift = (op_d == OP_IN) || (op_d == OP_RES);
  end

  // The sample is latched at accept, so the multiplier sees it for the input product
  // while the upstream side is already free.
  cuba_lif_mul #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (mul_ctl),
    .a_mag_i (mag_of(opa)),
    .b_mag_i (mag_of(opb)),
    .done_o  (mul_done),
    .term_o  (mul_term)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_SYN;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  // Accumulate the rounded terms. The new current is saturated one product later,
  // well before the drive product needs it.
  always_ff @(posedge clk_i) begin
    if (s_accept) sample_q <= s_axis_tdata;
    if (state_q == S_MUL && mul_done) begin
      case (op_q)
        OP_SYN:  sum_cur_q <= SW'(mul_term);
        OP_IN:   sum_cur_q <= sum_cur_q + SW'(mul_term);
        OP_MEM: begin
          sum_mem_q <= SW'(mul_term);
          cur_q     <= sat_dw(TW'(sum_cur_q));
        end
        OP_LEAK: sum_mem_q <= sum_mem_q + SW'(mul_term);
        OP_RES:  sum_mem_q <= sum_mem_q + SW'(mul_term);
        default: ;
      endcase
    end
    if (state_q == S_SAT) mem_q <= sat_dw(TW'(sum_mem_q));
  end

  // Strict compare against the threshold; on a spike either drop to the reset value
  // or subtract the threshold (the difference is positive then and cannot overflow).
  always_comb begin
    thr_sat = sat_dw(TW'(fire_thr_q));
    rp_sat  = sat_dw(TW'(reset_pot_q));
    fired   = mem_q > thr_sat;
    if (!fired)          vm_new = mem_q;
    else if (sub_mode_q) vm_new = mem_q - thr_sat;
    else                 vm_new = rp_sat;
    cur_ext = MagW'(cur_q);
    vm_ext  = MagW'(vm_new);
  end

  // Commit the step and load the result register once it is free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      syn_current_q <= '0;
      membrane_q    <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;
      if (state_q == S_FIRE && out_free) begin
        syn_current_q <= cur_q;
        membrane_q    <= vm_new;
        out_valid_q   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_FIRE && out_free) begin
      out_spike_q <= fired;
      out_data_q  <= {vm_ext[cuba_lif_pkg::OUT_W-1:0], cur_ext[cuba_lif_pkg::OUT_W-1:0]};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_spike_q;

endmodule

/* rtl/cuba_lif_chk.sv */
`include "assert_macros.svh"

module cuba_lif_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        cfg_ready_i
);

  // An accepted word keeps the block busy for at least the next cycle.
  `CHK_NEXT(a_busy_after_word, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // A new result appears only as the block returns to idle.
  `CHK_SAME(a_result_at_idle, $rose(m_axis_tvalid), s_axis_tready)

  // Register writes are never stalled.
  `CHK_SAME(a_cfg_ready, 1'b1, cfg_ready_i)

  // Hold a stalled result word.
  `CHK_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `CHK_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready,
            $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind cuba_lif_neuron_step cuba_lif_chk u_cuba_lif_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .cfg_ready_i   (cfg_ready_o)
);

/* dv/lif_step_checker.sv */
`timescale 1ns / 100ps

module lif_step_checker
  import cuba_lif_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  input  logic                     s_axis_tready,
  input  logic [SAMPLE_W-1:0]      s_axis_tdata,   // [31:0] in_sample
  input  logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  input  logic [2*OUT_W-1:0]       m_axis_tdata,   // [31:0] cur_out, [63:32] vm_out
  input  logic                     m_axis_tuser,   // [0] spike
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  output int                       mismatch_cnt_o,
  output int                       pending_o
);

  typedef struct packed {
    logic             spike;
    logic [OUT_W-1:0] cur;
    logic [OUT_W-1:0] vm;
  } step_result_t;

  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;

  step_result_t expected_steps_q[$];

  logic [DECAY_BITS-1:0] syn_decay_q, mem_decay_q;
  logic signed [31:0]    weight_q, resist_q, leak_q, reset_pot_q;
  logic [THR_W-1:0]      thr_q;
  logic                  sub_mode_q;
  logic signed [31:0]    cur_state, vm_state;
  int                    fails;

  function automatic longint clamp_word(input longint x);
    if (x > WORD_MAX) return WORD_MAX;
    if (x < WORD_MIN) return WORD_MIN;
    return x;
  endfunction

  // Exact product, magnitude rounded half away from zero, then saturated.
  function automatic longint scaled_product(input longint a, input longint b, input int sh);
    logic signed [127:0] prod;
    logic [127:0]        mag;
    logic [63:0]         lim;
    logic                neg;
    neg  = (a < 0) ^ (b < 0);
    prod = a * b;
    if (prod < 0) mag = -prod;
    else          mag = prod;
    mag = (mag + (128'd1 << (sh - 1))) >> sh;
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    if (mag > lim) mag = lim;
    return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
  endfunction

  function automatic step_result_t neuron_advance(input logic signed [31:0] sample);
    step_result_t res;
    longint       cur, mem, drive, omd, thr;
    cur   = clamp_word(scaled_product(cur_state, syn_decay_q, DECAY_BITS)
                       + scaled_product(weight_q, sample, FRAC_BITS_DEF));
    omd   = 65536 - longint'(mem_decay_q);
    drive = scaled_product(cur, omd, DECAY_BITS);
    mem   = clamp_word(scaled_product(vm_state, mem_decay_q, DECAY_BITS)
                       + scaled_product(leak_q, omd, DECAY_BITS)
                       + scaled_product(resist_q, drive, FRAC_BITS_DEF));
    thr       = longint'(thr_q);
    res.spike = (mem > thr);
    if (res.spike) mem = sub_mode_q ? clamp_word(mem - thr) : longint'(reset_pot_q);
    res.cur = cur[31:0];
    res.vm  = mem[31:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    step_result_t exp_r, got_r;
    if (!rst_ni) begin
      syn_decay_q  = SYN_DECAY_RST;
      mem_decay_q  = MEM_DECAY_RST;
      weight_q     = IN_WEIGHT_RST;
      resist_q     = MEM_RES_RST;
      leak_q       = LEAK_POT_RST;
      thr_q        = FIRE_THR_RST;
      reset_pot_q  = RESET_POT_RST;
      sub_mode_q   = SUB_MODE_RST;
      cur_state    = '0;
      vm_state     = '0;
      fails        = 0;
      expected_steps_q.delete();
      mismatch_cnt_o <= 0;
      pending_o      <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_SYN_DECAY: syn_decay_q = cfg_data_i[DECAY_BITS-1:0];
          CFG_MEM_DECAY: mem_decay_q = cfg_data_i[DECAY_BITS-1:0];
          CFG_IN_WEIGHT: weight_q    = cfg_data_i;
          CFG_MEM_RES:   resist_q    = cfg_data_i;
          CFG_LEAK_POT:  leak_q      = cfg_data_i;
          CFG_FIRE_THR:  thr_q       = cfg_data_i[THR_W-1:0];
          CFG_RESET_POT: reset_pot_q = cfg_data_i;
          CFG_SUB_MODE:  sub_mode_q  = cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        exp_r     = neuron_advance(s_axis_tdata);
        cur_state = exp_r.cur;
        vm_state  = exp_r.vm;
        expected_steps_q.push_back(exp_r);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_r = {m_axis_tuser, m_axis_tdata[OUT_W-1:0], m_axis_tdata[2*OUT_W-1:OUT_W]};
        if (expected_steps_q.size() == 0) begin
          $display("%0t: unexpected result word, got spike %0b cur %h vm %h",
                   $time, got_r.spike, got_r.cur, got_r.vm);
          fails++;
        end else begin
          exp_r = expected_steps_q.pop_front();
          if (got_r.spike !== exp_r.spike) begin
            $display("%0t: spike mismatch, expected %0b, got %0b",
                     $time, exp_r.spike, got_r.spike);
            fails++;
          end
          if (got_r.cur !== exp_r.cur) begin
            $display("%0t: cur_out mismatch, expected %h, got %h",
                     $time, exp_r.cur, got_r.cur);
            fails++;
          end
          if (got_r.vm !== exp_r.vm) begin
            $display("%0t: vm_out mismatch, expected %h, got %h",
                     $time, exp_r.vm, got_r.vm);
            fails++;
          end
        end
      end
      mismatch_cnt_o <= fails;
      pending_o      <= expected_steps_q.size();
    end
  end

endmodule

/* dv/tb_cuba_lif_neuron_step.sv */
`timescale 1ns / 100ps

module tb_cuba_lif_neuron_step;
  import cuba_lif_pkg::*;

  // Generous bound: ~1560 words plus sender gaps, receiver stalls and register
  // phases, taken several times over.
  localparam int CYCLE_LIMIT = 500000;
  // Idle margin at the end, run once every result has come back.
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_WORDS = 128;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [SAMPLE_W-1:0]   s_axis_tdata = '0;   // [31:0] in_sample
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [2*OUT_W-1:0]    m_axis_tdata;        // [31:0] cur_out, [63:32] vm_out
  logic                  m_axis_tuser;        // [0] spike
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  int mismatches;
  int pending;
  int cycle_cnt = 0;

  // Register values for the next phase, indexed by register code.
  logic [31:0] reg_vals [8];
  // Hand-picked input words for the directed phases.
  logic [31:0] directed_q[$];

  // Receiver stall pattern state.
  int       rx_mode = 0;
  int       rx_left = 0;
  logic [1:0] rx_phase = '0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  cuba_lif_neuron_step DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  lif_step_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .mismatch_cnt_o (mismatches),
    .pending_o      (pending)
  );

  // Receiver: switch at random between stall modes so that back-pressure lands
  // on every phase of the step, with fully open stretches.
  always @(posedge clk_i) begin
    rx_phase <= rx_phase + 2'd1;
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(16, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= (rx_phase == 2'd0);
      default: m_axis_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Hard stop if the run hangs.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Bits of the write data that the register keeps; the rest gets junk.
  function automatic logic [31:0] keep_mask(input cfg_idx_e idx);
    case (idx)
      CFG_SYN_DECAY, CFG_MEM_DECAY: return 32'h0000FFFF;
      CFG_FIRE_THR:                 return 32'h7FFFFFFF;
      CFG_SUB_MODE:                 return 32'h00000001;
      default:                      return 32'hFFFFFFFF;
    endcase
  endfunction

  // Mostly moderate, positive-leaning samples that drive the neuron over
  // threshold; the rest full-range or pinned at the extremes.
  function automatic logic [31:0] pick_sample(input bit wild);
    if (!wild && $urandom_range(0, 7) != 0) return $urandom_range(0, 2**19) - 2**17;
    case ($urandom_range(0, 5))
      0:       return 32'h7FFFFFFF;
      1:       return 32'h80000000;
      default: return $urandom();
    endcase
  endfunction

  // Fill reg_vals with a plausible neuron, or with extremes and noise.
  task automatic randomize_registers(input bit wild);
    int k;
    if (wild) begin
      for (k = 0; k < 8; k++) begin
        case ($urandom_range(0, 3))
          0:       reg_vals[k] = 32'h00000000;
          1:       reg_vals[k] = 32'h80000000;
          2:       reg_vals[k] = 32'h7FFFFFFF;
          default: reg_vals[k] = $urandom();
        endcase
      end
    end else begin
      reg_vals[CFG_SYN_DECAY] = $urandom_range(32768, 65535);
      reg_vals[CFG_MEM_DECAY] = $urandom_range(32768, 65535);
      reg_vals[CFG_IN_WEIGHT] = $urandom_range(0, 2**19) - 2**17;
      reg_vals[CFG_MEM_RES]   = $urandom_range(2**14, 2**19);
      if ($urandom_range(0, 5) == 0) reg_vals[CFG_MEM_RES] = -reg_vals[CFG_MEM_RES];
      reg_vals[CFG_LEAK_POT]  = $urandom_range(0, 2**17) - 2**16;
      reg_vals[CFG_FIRE_THR]  = $urandom_range(2**12, 2**18);
      reg_vals[CFG_RESET_POT] = $urandom_range(0, 2**17) - 2**16;
      reg_vals[CFG_SUB_MODE]  = $urandom_range(0, 1);
    end
  endtask

  // Write all eight registers back to back in a shuffled order.
  task automatic program_registers();
    cfg_idx_e    order [8];
    cfg_idx_e    tmp;
    int          j;
    logic [31:0] junk;
    logic [31:0] mask;
    for (int k = 0; k < 8; k++) order[k] = cfg_idx_e'(k);
    for (int k = 7; k > 0; k--) begin
      j        = $urandom_range(0, k);
      tmp      = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (int k = 0; k < 8; k++) begin
      junk = $urandom();
      mask = keep_mask(order[k]);
      cfg_valid_i <= 1'b1;
      cfg_index_i <= order[k];
      cfg_data_i  <= (reg_vals[order[k]] & mask) | (junk & ~mask);
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Offer one word and hold it until the block takes it.
  task automatic push_sample(input logic [31:0] val);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= val;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_directed();
    foreach (directed_q[k]) push_sample(directed_q[k]);
    s_axis_tvalid <= 1'b0;
    directed_q.delete();
  endtask

  // Send in bursts of random length; gaps between bursts are sometimes zero.
  task automatic send_samples(input int count, input bit wild);
    int burst;
    int gap;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst--;
      push_sample(pick_sample(wild));
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // Wait on the clock until every result has come back, checking only after an edge.
  task automatic wait_drained();
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    bit wild;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults: unit weight, 0.9 decays, threshold 1.0. Build up to a
    // spike, then drive the current into both saturation limits.
    directed_q = '{32'h00000000, 32'h00000001, 32'hFFFFFFFF, 32'h00018000,
                   32'h00018000, 32'h00018000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                   32'h80000000, 32'h80000000};
    send_directed();
    wait_drained();

    // Extremes, zero threshold in subtract mode: any positive membrane fires.
    reg_vals[CFG_SYN_DECAY] = 32'h0000FFFF;
    reg_vals[CFG_MEM_DECAY] = 32'h00000000;
    reg_vals[CFG_IN_WEIGHT] = 32'h7FFFFFFF;
    reg_vals[CFG_MEM_RES]   = 32'h80000000;
    reg_vals[CFG_LEAK_POT]  = 32'h7FFFFFFF;
    reg_vals[CFG_FIRE_THR]  = 32'h00000000;
    reg_vals[CFG_RESET_POT] = 32'h80000000;
    reg_vals[CFG_SUB_MODE]  = 32'h00000001;
    program_registers();
    directed_q = '{32'h7FFFFFFF, 32'h80000000, 32'h00000001, 32'hFFFFFFFF,
                   32'h00000000, 32'h00010000};
    send_directed();
    wait_drained();

    // Opposite extremes: no current memory, full membrane memory, maximum
    // threshold and reset to the top of the range.
    reg_vals[CFG_SYN_DECAY] = 32'h00000000;
    reg_vals[CFG_MEM_DECAY] = 32'h0000FFFF;
    reg_vals[CFG_IN_WEIGHT] = 32'h80000000;
    reg_vals[CFG_MEM_RES]   = 32'h7FFFFFFF;
    reg_vals[CFG_LEAK_POT]  = 32'h80000000;
    reg_vals[CFG_FIRE_THR]  = 32'h7FFFFFFF;
    reg_vals[CFG_RESET_POT] = 32'h7FFFFFFF;
    reg_vals[CFG_SUB_MODE]  = 32'h00000000;
    program_registers();
    directed_q = '{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h00000001,
                   32'hFFFFFFFF, 32'h00008000};
    send_directed();
    wait_drained();

    // Random phases: reprogram only once the block has gone idle.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wild = ($urandom_range(0, 3) == 0);
      randomize_registers(wild);
      program_registers();
      send_samples(PHASE_WORDS, wild);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
